FILE: src/ppmfd_pkg.sv
// Shared types and constants for the PPM frame decoder.
`timescale 1ns / 1ps
package ppmfd_pkg;

  localparam int unsigned StampW = 16;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned SyncW  = 8;
  localparam int unsigned ChanW  = 3;

  typedef enum logic [1:0] {
    EV_SYNC    = 2'd0,
    EV_STORED  = 2'd1,
    EV_OVERRUN = 2'd2,
    EV_REJECT  = 2'd3
  } ppmfd_event_e;

  typedef enum logic [1:0] {
    REG_SYNC_GAP   = 2'd0,
    REG_MIN_WIDTH  = 2'd1,
    REG_MAX_WIDTH  = 2'd2,
    REG_SYNC_LIMIT = 2'd3
  } ppmfd_reg_e;

  localparam logic [StampW-1:0] SyncGapRst   = 16'd20000;
  localparam logic [StampW-1:0] MinWidthRst  = 16'd3500;
  localparam logic [StampW-1:0] MaxWidthRst  = 16'd8500;
  localparam logic [SyncW-1:0]  SyncLimitRst = 8'd10;

  typedef struct packed {
    logic [StampW-1:0] sync_gap;
    logic [StampW-1:0] min_width;
    logic [StampW-1:0] max_width;
    logic [SyncW-1:0]  sync_limit;
  } ppmfd_cfg_t;

  typedef struct packed {
    logic [StampW-1:0] last_stamp;
    logic [IdxW-1:0]   chan_idx;
    logic [SyncW-1:0]  sync_level;
  } ppmfd_state_t;

  typedef struct packed {
    ppmfd_event_e      kind;
    logic [ChanW-1:0]  chan;
    logic [StampW-1:0] width;
    logic              done;
    logic [SyncW-1:0]  sync;
  } ppmfd_result_t;

endpackage

FILE: src/ppmfd_step.sv
// Per-stamp decode: interval, classification and next decoder state.
`timescale 1ns / 1ps
module ppmfd_step #(
  parameter int unsigned NUM_CHANNELS = 7
) (
  input  logic [ppmfd_pkg::StampW-1:0] stamp_i,
  input  ppmfd_pkg::ppmfd_cfg_t        cfg_i,
  input  ppmfd_pkg::ppmfd_state_t      state_i,
  output ppmfd_pkg::ppmfd_state_t      state_o,
  output ppmfd_pkg::ppmfd_result_t     result_o
);

  localparam logic [ppmfd_pkg::IdxW-1:0] LastChan = ppmfd_pkg::IdxW'(NUM_CHANNELS);

  logic [ppmfd_pkg::StampW-1:0] interval;
  logic is_sync;
  logic is_width;
  logic idx_ok;

  assign interval = stamp_i - state_i.last_stamp;
  assign is_sync  = interval > cfg_i.sync_gap;
  assign is_width = (interval > cfg_i.min_width) && (interval < cfg_i.max_width);
  assign idx_ok   = (state_i.chan_idx != '0) && (state_i.chan_idx <= LastChan);

  always_comb begin
    state_o        = state_i;
    result_o.kind  = ppmfd_pkg::EV_REJECT;
    result_o.chan  = '0;
    result_o.width = interval;
    result_o.done  = 1'b0;
    if (is_sync) begin
      result_o.kind    = ppmfd_pkg::EV_SYNC;
      state_o.last_stamp = stamp_i;
      state_o.chan_idx   = ppmfd_pkg::IdxW'(1);
      if (state_i.sync_level < cfg_i.sync_limit) begin
        state_o.sync_level = state_i.sync_level + 1'b1;
      end
    end else if (is_width) begin
      state_o.last_stamp = stamp_i;
      if (idx_ok) begin
        result_o.kind    = ppmfd_pkg::EV_STORED;
        result_o.chan    = state_i.chan_idx[ppmfd_pkg::ChanW-1:0];
        result_o.done    = (state_i.chan_idx == LastChan);
        state_o.chan_idx = state_i.chan_idx + 1'b1; // wraps mod 16
      end else begin
        result_o.kind    = ppmfd_pkg::EV_OVERRUN;
        state_o.chan_idx = ppmfd_pkg::IdxW'(1);
        if (state_i.sync_level != '0) begin
          state_o.sync_level = state_i.sync_level - 1'b1;
        end
      end
    end else begin
      state_o.sync_level = '0;
    end
    result_o.sync = state_o.sync_level;
  end

endmodule

FILE: src/ppm_frame_decoder_core.sv
// Top level of the PPM frame decoder: input register, decode, result register.
// A stamp is taken into the input register; its result is then registered for output.
// Throughput: one stamp per cycle while the output is not stalled; the interval and
// state update are combinational between the input register and the result register.
// Reset: rst_ni clears both stages, the decoder state and loads the default thresholds.
`timescale 1ns / 1ps
module ppm_frame_decoder_core #(
  parameter int unsigned NUM_CHANNELS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] capture_stamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [2:0]  channel_number_o,
  output logic [15:0] pulse_width_o,
  output logic        frame_done_o,
  output logic [7:0]  sync_count_o
);

  ppmfd_pkg::ppmfd_cfg_t    cfg_q;
  ppmfd_pkg::ppmfd_state_t  state_q, state_d;
  ppmfd_pkg::ppmfd_result_t res_q, res_d;

  logic        in_valid_q;
  logic [15:0] stamp_q;
  logic        out_valid_q;
  logic        out_adv;
  logic        in_take;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_gap   <= ppmfd_pkg::SyncGapRst;
      cfg_q.min_width  <= ppmfd_pkg::MinWidthRst;
      cfg_q.max_width  <= ppmfd_pkg::MaxWidthRst;
      cfg_q.sync_limit <= ppmfd_pkg::SyncLimitRst;
    end else if (cfg_we_i) begin
      case (ppmfd_pkg::ppmfd_reg_e'(cfg_idx_i))
        ppmfd_pkg::REG_SYNC_GAP:   cfg_q.sync_gap   <= cfg_data_i;
        ppmfd_pkg::REG_MIN_WIDTH:  cfg_q.min_width  <= cfg_data_i;
        ppmfd_pkg::REG_MAX_WIDTH:  cfg_q.max_width  <= cfg_data_i;
        ppmfd_pkg::REG_SYNC_LIMIT: cfg_q.sync_limit <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ppmfd_step #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_step (
    .stamp_i  (stamp_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Control and decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  // Payload beats.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stamp_q <= capture_stamp_i;
    end
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = res_q.kind;
  assign channel_number_o = res_q.chan;
  assign pulse_width_o    = res_q.width;
  assign frame_done_o     = res_q.done;
  assign sync_count_o     = res_q.sync;

endmodule

FILE: src/ppmfd_checker.sv
// Port-level assertions for the PPM frame decoder, bound to the top level.
`timescale 1ns / 1ps
module ppmfd_checker #(
  parameter int unsigned NUM_CHANNELS = 7
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  event_kind_o,
  input logic [2:0]  channel_number_o,
  input logic [15:0] pulse_width_o,
  input logic        frame_done_o,
  input logic [7:0]  sync_count_o
);

  // A held result beat stays valid and keeps its event kind, pulse width and sync count.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pulse_width_o)
      && $stable(event_kind_o) && $stable(sync_count_o))
    else $error("result beat changed while stalled");

  // Input backpressure only comes from a stalled full output.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_chan_only_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != ppmfd_pkg::EV_STORED)
      |-> (channel_number_o == 3'd0) && !frame_done_o)
    else $error("channel fields set outside a stored beat");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> channel_number_o == 3'(NUM_CHANNELS))
    else $error("frame done on a channel other than the last");

  a_reject_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == ppmfd_pkg::EV_REJECT) |-> sync_count_o == 8'd0)
    else $error("rejected interval left sync count nonzero");

endmodule

bind ppm_frame_decoder_core ppmfd_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_ppmfd_checker (.*);
